// ===== hdl/tkt_pkg.sv =====
// ----------------------------------------------------------------------------
// tkt_pkg: shared types and constants for the top-k threshold tracker
// Capacity of the cell chain, field widths, and the structs that link cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tkt_pkg;

  localparam int K_MAX   = 16;
  localparam int VAL_W   = 32;
  localparam int KCFG_W  = 5;
  localparam int IDX_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  // Data handed from one cell to the next one down the chain.
  typedef struct packed {
    logic             take;
    logic             valid;
    logic [VAL_W-1:0] value;
  } link_t;

  // Command broadcast to every cell for the current cycle.
  typedef struct packed {
    logic insert;
    logic clear;
    logic cfg;
  } cmd_t;

  // Next contents of a cell, used to form the result.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/tkt_cell.sv =====
// ----------------------------------------------------------------------------
// tkt_cell: one slot of the sorted insertion chain
// Holds one kept value; takes the new value, its upper neighbor's value, or
// keeps its own, so the chain stays sorted from high to low.
// ----------------------------------------------------------------------------
`default_nettype none

module tkt_cell
  import tkt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic             active_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire link_t            prev_i,
  output link_t                 link_o,
  output entry_t                next_o
);

  logic             valid_q, valid_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             take;

  // The new value belongs here when this slot is in use by k and holds
  // nothing that is at least as large.
  assign take = active_i && !(valid_q && (value_q >= value_i));

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.cfg) begin
      valid_d = valid_q && active_i;
    end else if (cmd_i.insert) begin
      if (!active_i) begin
        valid_d = 1'b0;
      end else if (prev_i.take) begin
        valid_d = prev_i.valid;
        value_d = prev_i.value;
      end else if (take) begin
        valid_d = 1'b1;
        value_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o = '{take: take, valid: valid_q, value: value_q};
  assign next_o = '{valid: valid_d, value: value_d};

endmodule

`default_nettype wire

// ===== hdl/top_k_threshold_tracker.sv =====
// ----------------------------------------------------------------------------
// top_k_threshold_tracker: keeps the k largest values seen since the last clear
// The result of an item is registered at its transfer and presented in the cycle after it.
// Throughput: one item per cycle; every cell compares and shifts in parallel,
// and the single output register holds back input only while it is stalled.
// A configuration write that is offered also holds back input for that cycle.
// Reset: asynchronous, active low; all cells empty, k_in_use reads 16.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_threshold_tracker
  import tkt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write channel: k_in_use.
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [KCFG_W-1:0] cfg_data_i,
  // Input stream.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,   // [31:0] value
  input  wire logic [0:0]        s_axis_tuser,   // [0] op (1 = clear)
  // Result stream.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [31:0]            m_axis_tdata,   // [31:0] threshold
  output logic [0:0]             m_axis_tuser    // [0] full_res
);

  // The raw register value is kept; the effective k clamps it to 1..K_MAX.
  logic [KCFG_W-1:0] k_q, k_d;
  logic [KCFG_W-1:0] k_raw, k_eff;
  logic [IDX_W-1:0]  k_sel;

  logic              s_xfer, cfg_xfer;
  cmd_t              cmd;

  link_t             link [K_MAX+1];
  entry_t            nxt  [K_MAX];
  logic [K_MAX-1:0]  cell_valid;

  logic              m_valid_q;
  logic [VAL_W-1:0]  m_thr_q, m_thr_d;
  logic              m_full_q, m_full_d;

  assign cfg_ready_o   = 1'b1;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;
  // The cells apply either a configuration write or an item at a time, not both, so
  // an offered write takes the cycle and the input waits.
  assign s_axis_tready = (!m_valid_q || m_axis_tready) && !cfg_valid_i;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign k_d   = cfg_xfer ? cfg_data_i : k_q;
  // A write changes the active span of the chain in the same cycle, so the
  // cells drop anything beyond the new k right away.
  assign k_raw = k_d;

  always_comb begin
    priority if (k_raw == '0) begin
      k_eff = KCFG_W'(1);
    end else if (k_raw > KCFG_W'(K_MAX)) begin
      k_eff = KCFG_W'(K_MAX);
    end else begin
      k_eff = k_raw;
    end
  end

  assign k_sel = IDX_W'(k_eff - KCFG_W'(1));

  assign cmd.insert = s_xfer && !s_axis_tuser[0];
  assign cmd.clear  = s_xfer &&  s_axis_tuser[0];
  assign cmd.cfg    = cfg_xfer;

  // Nothing moves into the head of the chain from above.
  assign link[0] = '{take: 1'b0, valid: 1'b0, value: '0};

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic active;
    assign active = (KCFG_W'(i) < k_eff);

    tkt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .active_i(active),
      .value_i (s_axis_tdata),
      .prev_i  (link[i]),
      .link_o  (link[i+1]),
      .next_o  (nxt[i])
    );

    assign cell_valid[i] = link[i+1].valid;
  end

  // The list is full exactly when the k-th cell will hold a value, because
  // valid cells always form an unbroken run from the head.
  assign m_full_d = nxt[k_sel].valid;
  assign m_thr_d  = m_full_d ? nxt[k_sel].value : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= KCFG_W'(K_MAX);
      m_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (s_xfer) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      m_thr_q  <= m_thr_d;
      m_full_q <= m_full_d;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_thr_q;
  assign m_axis_tuser[0] = m_full_q;

  // A result that is not full always carries a zero threshold.
  a_thr_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("threshold not zero while list is not full");

  // A clear is answered by an empty, not-full result in the next cycle.
  a_clear_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0])
      |=> (m_axis_tvalid && !m_axis_tuser[0]))
    else $error("clear did not give an empty result");

  // Valid cells form a run starting at the head of the chain.
  a_valid_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid & ~{cell_valid[K_MAX-1:0] << 1 | K_MAX'(1)}) == '0))
    else $error("gap in the run of valid cells");

endmodule

`default_nettype wire

// ===== test/tb_top_k_threshold_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_top_k_threshold_tracker: self-checking bench for the top-k threshold tracker
// Streams insert and clear items under random back-pressure, keeps a model of
// the sorted top-k list, and compares every result transfer against it. The
// k_in_use register is reprogrammed between phases, out-of-range codes included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top_k_threshold_tracker;
  import tkt_pkg::*;

  // Operation carried in tuser[0] of the input stream.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } tkt_op_e;

  typedef struct packed {
    tkt_op_e          op;
    logic [VAL_W-1:0] value;
  } support_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] threshold;
    logic             full;
  } prune_result_t;

  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int PHASE_ITEMS = 148;   // random items per k_in_use setting
  localparam int IDLE_PCT    = 17;
  localparam int NUM_PHASES  = 11;
  localparam int REPORT_MAX  = 10;

  // Settings visited by the random phases. The codes 0, 17 and 31 lie outside
  // 1..K_MAX and must be clamped by the block.
  localparam logic [KCFG_W-1:0] K_PLAN [NUM_PHASES] =
    '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd3, 5'd8, 5'd4, 5'd15, 5'd5};

  // DUT signals. Every input starts at a known value.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [KCFG_W-1:0] cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;   // [31:0] value
  logic [0:0]        s_axis_tuser  = '0;   // [0] op (1 = clear)
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;         // [31:0] threshold
  logic [0:0]        m_axis_tuser;         // [0] full_res

  // Model state: the kept list, its fill level and the raw register value.
  logic [VAL_W-1:0]  kept_list [K_MAX];
  int                kept_count;
  logic [KCFG_W-1:0] k_in_use_reg;

  // Items waiting to be driven, and results waiting to be seen.
  support_item_t     support_q [$];
  prune_result_t     threshold_q [$];

  // Bookkeeping shared between the stimulus, driver and monitor.
  bit                item_taken   = 1'b0;
  bit                calm         = 1'b0;  // no idling on either side
  int                items_queued = 0;
  int                items_in     = 0;
  int                results_out  = 0;
  int                clears_in    = 0;
  int                full_results = 0;
  int                cfg_writes   = 0;
  int                fail_count   = 0;
  int                stall_cycles = 0;
  logic [VAL_W-1:0]  ramp_value   = '0;

  top_k_threshold_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The register is five bits wide, so codes outside 1..K_MAX are clamped.
  function automatic int k_effective();
    int k;
    k = int'(k_in_use_reg);
    if (k < 1) k = 1;
    if (k > K_MAX) k = K_MAX;
    return k;
  endfunction

  // A register write takes effect at once: when k shrinks, the smallest
  // entries fall off and stay lost even if k grows again later.
  function automatic void write_k_in_use(logic [KCFG_W-1:0] code);
    k_in_use_reg = code;
    if (kept_count > k_effective()) kept_count = k_effective();
  endfunction

  // Applies one item to the kept list and returns the result it produces.
  function automatic prune_result_t track_top_k(support_item_t item);
    prune_result_t res;
    int            k;
    int            pos;
    int            fill;
    k = k_effective();
    if (item.op == OP_CLEAR) begin
      foreach (kept_list[i]) kept_list[i] = '0;
      kept_count = 0;
    end else begin
      if (kept_count > k) kept_count = k;
      // Once full, a value must strictly beat the smallest entry; a tie with
      // it is turned away. Until then every value goes in, duplicates too.
      if (!(kept_count == k && item.value <= kept_list[k-1])) begin
        pos = 0;
        while (pos < kept_count && kept_list[pos] >= item.value) pos++;
        fill = (kept_count < k) ? kept_count + 1 : k;
        for (int i = fill - 1; i > pos; i--) kept_list[i] = kept_list[i-1];
        if (pos < fill) kept_list[pos] = item.value;
        kept_count = fill;
      end
    end
    res.full      = (kept_count >= k);
    res.threshold = res.full ? kept_list[k-1] : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  function automatic void queue_item(tkt_op_e op, logic [VAL_W-1:0] value);
    support_item_t item;
    item.op    = op;
    item.value = value;
    support_q = {support_q, item};
    items_queued++;
  endfunction

  // Mix of value shapes: a narrow band gives many ties, a wider band reaches 4000, full-range
  // values toggle every bit, extremes hit the ends, and a rising ramp keeps evicting.
  function automatic logic [VAL_W-1:0] pick_support();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return VAL_W'($urandom_range(0, 24));
    if (roll < 55) return VAL_W'($urandom);
    if (roll < 65) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFE;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (roll < 85) return VAL_W'($urandom_range(0, 4000));
    ramp_value = ramp_value + VAL_W'($urandom_range(1, 50));
    return ramp_value;
  endfunction

  // Holds the sender back until every item has gone in and every result has
  // come back, then lets the pipeline settle before anything else happens.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_in != items_queued || results_out != items_in);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_k(logic [KCFG_W-1:0] code);
    int writes_seen;
    writes_seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(negedge clk_i);
    while (cfg_writes == writes_seen);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items at the falling edge, holding each one until
  // its transfer, and idles now and then unless a calm stretch is running.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    support_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || item_taken) begin
      item_taken = 1'b0;
      if (support_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        item = support_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.value;
        s_axis_tuser  <= item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, also changed at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples all three channels at the rising edge. The result check
  // runs before a new expectation is pushed, so a result that shows up with
  // nothing outstanding can never be matched against an item taken this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    prune_result_t want;
    support_item_t item;
    bit            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        write_k_in_use(cfg_data_i);
        cfg_writes++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        moved = 1'b1;
        if (threshold_q.size() == 0) begin
          note_failure($sformatf("result transfer with nothing outstanding: threshold %h full %b",
                                 m_axis_tdata, m_axis_tuser[0]));
        end else begin
          want = threshold_q.pop_front();
          if (m_axis_tdata !== want.threshold || m_axis_tuser[0] !== want.full) begin
            note_failure($sformatf("result %0d: expected threshold %h full %b, got %h full %b",
                                   results_out, want.threshold, want.full,
                                   m_axis_tdata, m_axis_tuser[0]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item.op    = tkt_op_e'(s_axis_tuser[0]);
        item.value = s_axis_tdata;
        want       = track_top_k(item);
        threshold_q = {threshold_q, want};
        if (item.op == OP_CLEAR) clears_in++;
        if (want.full) full_results++;
        items_in++;
        item_taken = 1'b1;
        moved      = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: a run that stops making transfers is a failure.
  initial begin : watchdog
    do @(posedge clk_i);
    while (stall_cycles < STALL_LIMIT);
    $display("Timeout: no transfer on any channel for %0d cycles.", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    foreach (kept_list[i]) kept_list[i] = '0;
    kept_count   = 0;
    k_in_use_reg = 5'd16;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset setting of k = 16: fill the list with both
    // extremes, then check that ties with the smallest entry are rejected,
    // that a larger value evicts it, and that a duplicate of the top is kept.
    queue_item(OP_CLEAR, 32'hFFFF_FFFF);
    queue_item(OP_INSERT, 32'h0000_0000);
    queue_item(OP_INSERT, 32'hFFFF_FFFF);
    for (int v = 10; v < 24; v++) queue_item(OP_INSERT, VAL_W'(v));
    queue_item(OP_INSERT, 32'h0000_0000);
    queue_item(OP_INSERT, 32'h0000_0001);
    queue_item(OP_INSERT, 32'h0000_0001);
    queue_item(OP_INSERT, 32'hFFFF_FFFF);
    queue_item(OP_CLEAR, 32'h0000_0000);
    wait_drained();

    // With k of one the very first insert must already report a full list.
    write_k(5'd1);
    queue_item(OP_INSERT, 32'h0000_0007);
    queue_item(OP_INSERT, 32'h0000_0007);
    queue_item(OP_INSERT, 32'h0000_0003);
    queue_item(OP_INSERT, 32'hFFFF_FFFF);
    queue_item(OP_CLEAR, 32'h5555_5555);
    wait_drained();

    // Random phases. No extra clear is queued before a register write, so shrinking k
    // truncates a populated list. One phase runs without any idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_k(K_PLAN[p]);
      calm = (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_item(($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_INSERT, pick_support());
      end
      wait_drained();
      calm = 1'b0;
    end

    repeat (5) @(negedge clk_i);
    if (threshold_q.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", threshold_q.size()));
    end

    $display("Run covered %0d items (%0d clears) across %0d k_in_use writes, codes 0 and 31 included.",
             items_in, clears_in, cfg_writes);
    $display("%0d results compared, %0d of them with the list full; %0d failures.",
             results_out, full_results, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
